/* rtl/baro_pkg.sv */
`default_nettype none

package baro_pkg;

   localparam int LOG_TABLE_BITS_DEF = 8;

   // field widths
   localparam int P_W   = 20;
   localparam int V_W   = 32;
   localparam int H_W   = 27;
   localparam int HV_W  = 40;
   localparam int P0_W  = 17;
   localparam int T0_W  = 19;
   localparam int LR_W  = 14;
   localparam int E_W   = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // register reset values
   localparam logic [P0_W-1:0] P0_RST = 17'd101325;
   localparam logic [T0_W-1:0] T0_RST = 19'd288150;
   localparam logic [LR_W-1:0] LR_RST = 14'd6500;
   localparam logic [E_W-1:0]  E_RST  = 20'd199505;

   localparam int MILLIBAR_PA = 100;
   localparam int MICRO_SCALE = 1000000;

   // table entry widths: log2 in Q.24, exp2 in Q.30
   localparam int LOGV_W = 25;
   localparam int EXPV_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_P0  = 2'd0,
      CSR_T0  = 2'd1,
      CSR_LR  = 2'd2,
      CSR_EXP = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [4:0]  k;
      logic [29:0] off;
   } norm_type;

   typedef struct packed {
      logic             pos;
      logic             sat;
      logic [P_W-2:0]   p;
      logic [V_W-1:0]   v;
      logic [H_W-1:0]   h;
   } item_type;

   // leading one position and mantissa offset of a value below 2^30
   function automatic norm_type normalize(input logic [29:0] x);
      norm_type    r;
      logic [30:0] sh;
      r.k = '0;
      for (int i = 1; i < 30; i++) begin
         if (x[i]) r.k = 5'(i);
      end
      sh = {1'b0, x} << (5'd30 - r.k);
      r.off = sh[29:0];
      return r;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x = xin;
      res = '0;
      bit_v = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bit_v > x) bit_v = bit_v >> 2;
      end
      for (int j = 0; j < 32; j++) begin
         if (bit_v != 0) begin
            if (x >= res + bit_v) begin
               x = x - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // log2(1 + i/2^bits) in Q.24 by repeated squaring
   function automatic logic [LOGV_W-1:0] log_entry(input int i, input int bits);
      logic [63:0] mnt;
      logic [63:0] res;
      mnt = (64'd1 << 30) + (64'(i) << (30 - bits));
      res = '0;
      if (mnt >= (64'd1 << 31)) begin
         res = 64'd1 << 24;
         mnt = mnt >> 1;
      end
      for (int k = 23; k >= 0; k--) begin
         mnt = (mnt * mnt) >> 30;
         if (mnt >= (64'd1 << 31)) begin
            res = res | (64'd1 << k);
            mnt = mnt >> 1;
         end
      end
      return res[LOGV_W-1:0];
   endfunction

   // 2^(i/2^bits) in Q.30 as a product of root-of-two factors
   function automatic logic [EXPV_W-1:0] exp_entry(input int i, input int bits);
      logic [63:0] f;
      logic [63:0] acc;
      logic [63:0] c;
      f = 64'(i) << (24 - bits);
      acc = 64'd1 << 30;
      c = isqrt64(64'd1 << 61);
      if (f >= (64'd1 << 24)) begin
         acc = 64'd1 << 31;
      end else begin
         for (int k = 23; k >= 0; k--) begin
            if (f[k]) acc = (acc * c) >> 30;
            c = isqrt64(c << 30);
         end
      end
      return acc[EXPV_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/barometric_altitude_with_variance.sv */
`default_nettype none

// Barometric altimeter: pressure sample in, altitude and altitude variance out.
// Input channel: a transaction is taken at a rising edge where start is high and
// busy is low; req_pressure_mb_q8 (signed Q.8 mb) and req_variance_mb2_q16 are
// sampled there. One transaction can be taken every cycle while busy is low.
// Result channel: rsp_strobe is high for exactly one cycle per transaction with
// rsp_height_mm, rsp_height_var_mm2 and rsp_valid_res; the receiver cannot
// stall, so results leave in order at the rate they came in.
// Datapath: the rsp_ ports are driven through the 60 stage pipeline (log2 and exp2
// table lookups, split multipliers, and a 44 step restoring divider for the
// variance gain) and an output register.
// Throughput: one transaction per cycle while busy is low.
// Config: csr_we writes csr_wdata to register csr_index in the same edge. Any
// write, and reset, restarts a bit-serial divider for T0*10^6/L; busy stays high
// while it runs. Write only while no transaction is in flight.
// Reset: synchronous, clears the pipeline valid bits and the registers to their
// standard-atmosphere values; busy is high after reset while that divider runs.
// A pressure of zero or below gives height 0, variance 0 and rsp_valid_res low.

module barometric_altitude_with_variance #(
   parameter int LOG_TABLE_BITS = baro_pkg::LOG_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [baro_pkg::P_W-1:0]     req_pressure_mb_q8,
   input  logic [baro_pkg::V_W-1:0]            req_variance_mb2_q16,
   output logic                                rsp_strobe,
   output logic signed [baro_pkg::H_W-1:0]     rsp_height_mm,
   output logic [baro_pkg::HV_W-1:0]           rsp_height_var_mm2,
   output logic                                rsp_valid_res,
   input  logic                                csr_we,
   input  logic [baro_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [baro_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int TAB_N   = (1 << LOG_TABLE_BITS) + 1;
   localparam int TAB_IW  = LOG_TABLE_BITS + 1;
   localparam int LOG_SH  = 30 - LOG_TABLE_BITS;
   localparam int EXP_SH  = 24 - LOG_TABLE_BITS;
   localparam int LOGP_W  = baro_pkg::LOGV_W + LOG_SH;
   localparam int EXPP_W  = baro_pkg::EXPV_W + EXP_SH;
   localparam int LV_W    = 29;
   localparam int K_W     = 39;
   localparam int KDIV_STEPS = K_W;
   localparam int RP_W    = 50;
   localparam int A_W     = 47;
   localparam int G_W     = 44;
   localparam int PP_W    = baro_pkg::P_W - 1;

   localparam int ST_J    = 9;
   localparam int ST_N    = 12;
   localparam int NUM_ST  = ST_N + G_W + 4;
   localparam int LATENCY = NUM_ST + 1;

   // ---------------------------------------------------------------- config
   logic [baro_pkg::P0_W-1:0] p0_ff;
   logic [baro_pkg::T0_W-1:0] t0_ff;
   logic [baro_pkg::LR_W-1:0] lr_ff;
   logic [baro_pkg::E_W-1:0]  ex_ff;
   logic [baro_pkg::P0_W-1:0] p0_eff;
   logic [baro_pkg::LR_W-1:0] lr_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff <= baro_pkg::P0_RST;
         t0_ff <= baro_pkg::T0_RST;
         lr_ff <= baro_pkg::LR_RST;
         ex_ff <= baro_pkg::E_RST;
      end else if (csr_we) begin
         unique case (baro_pkg::csr_index_type'(csr_index))
            baro_pkg::CSR_P0:  p0_ff <= csr_wdata[baro_pkg::P0_W-1:0];
            baro_pkg::CSR_T0:  t0_ff <= csr_wdata[baro_pkg::T0_W-1:0];
            baro_pkg::CSR_LR:  lr_ff <= csr_wdata[baro_pkg::LR_W-1:0];
            baro_pkg::CSR_EXP: ex_ff <= csr_wdata[baro_pkg::E_W-1:0];
            default: ;
         endcase
      end
   end

   assign p0_eff = (p0_ff == '0) ? baro_pkg::P0_W'(1) : p0_ff;
   assign lr_eff = (lr_ff == '0) ? baro_pkg::LR_W'(1) : lr_ff;

   // ---------------------------------------------- kmm = T0 * 10^6 / L, serial
   logic            kload_ff;
   logic [5:0]      kcnt_ff;
   logic [K_W-1:0]  knum_ff;
   logic [baro_pkg::LR_W-1:0] krem_ff;
   logic [baro_pkg::LR_W-1:0] krem_in;
   logic [baro_pkg::LR_W:0]   ktrial;
   logic            kge;

   always_ff @(posedge clock) begin
      if (reset) begin
         kload_ff <= 1'b1;
         kcnt_ff  <= '0;
      end else if (csr_we) begin
         kload_ff <= 1'b1;
         kcnt_ff  <= '0;
      end else if (kload_ff) begin
         kload_ff <= 1'b0;
         kcnt_ff  <= 6'(KDIV_STEPS);
      end else if (kcnt_ff != '0) begin
         kcnt_ff  <= kcnt_ff - 6'd1;
      end
   end

   assign ktrial  = {krem_ff, knum_ff[K_W-1]};
   assign kge     = ktrial >= {1'b0, lr_eff};
   assign krem_in = kge ? baro_pkg::LR_W'(ktrial - {1'b0, lr_eff})
                        : ktrial[baro_pkg::LR_W-1:0];

   always_ff @(posedge clock) begin
      if (kload_ff) begin
         knum_ff <= K_W'(t0_ff) * K_W'(baro_pkg::MICRO_SCALE);
         krem_ff <= '0;
      end else if (kcnt_ff != '0) begin
         knum_ff <= {knum_ff[K_W-2:0], kge};
         krem_ff <= krem_in;
      end
   end

   assign busy = kload_ff | (kcnt_ff != '0);

   // ---------------------------------------------------------------- tables
   logic [baro_pkg::LOGV_W-1:0] log_tab [TAB_N];
   logic [baro_pkg::EXPV_W-1:0] exp_tab [TAB_N];

   for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
      assign log_tab[gi] = baro_pkg::log_entry(gi, LOG_TABLE_BITS);
      assign exp_tab[gi] = baro_pkg::exp_entry(gi, LOG_TABLE_BITS);
   end

   function automatic logic [baro_pkg::LOGV_W-1:0] log_interp(
      input logic [baro_pkg::LOGV_W-1:0] t0,
      input logic [baro_pkg::LOGV_W-1:0] t1,
      input logic [LOG_SH-1:0]           fr);
      logic [LOGP_W-1:0] prod;
      prod = LOGP_W'(t1 - t0) * LOGP_W'(fr);
      return (t1 < t0) ? t0 : t0 + prod[LOGP_W-1:LOG_SH];
   endfunction

   function automatic logic [baro_pkg::EXPV_W-1:0] exp_interp(
      input logic [baro_pkg::EXPV_W-1:0] t0,
      input logic [baro_pkg::EXPV_W-1:0] t1,
      input logic [EXP_SH-1:0]           fr);
      logic [EXPP_W-1:0] prod;
      prod = EXPP_W'(t1 - t0) * EXPP_W'(fr);
      return (t1 < t0) ? t0 : t0 + prod[EXPP_W-1:EXP_SH];
   endfunction

   // ------------------------------------ log2(256 * P0), settles within busy
   baro_pkg::norm_type          l2n_ff;
   logic [baro_pkg::LOGV_W-1:0] l2t0_ff;
   logic [baro_pkg::LOGV_W-1:0] l2t1_ff;
   logic [LOG_SH-1:0]           l2fr_ff;
   logic [4:0]                  l2k_ff;
   logic [LV_W-1:0]             l2_ff;
   logic [LOG_TABLE_BITS-1:0]   l2_idx;

   assign l2_idx = l2n_ff.off[29:LOG_SH];

   always_ff @(posedge clock) begin
      l2n_ff  <= baro_pkg::normalize({5'b0, p0_eff, 8'b0});
      l2t0_ff <= log_tab[TAB_IW'(l2_idx)];
      l2t1_ff <= log_tab[TAB_IW'(l2_idx) + TAB_IW'(1)];
      l2fr_ff <= l2n_ff.off[LOG_SH-1:0];
      l2k_ff  <= l2n_ff.k;
      l2_ff   <= {l2k_ff, 24'b0} + LV_W'(log_interp(l2t0_ff, l2t1_ff, l2fr_ff));
   end

   // ------------------------------------------------------- pipeline control
   logic                accept;
   logic                vld_ff [NUM_ST];
   baro_pkg::item_type  itm_ff [NUM_ST];
   baro_pkg::item_type  itm_in [NUM_ST];
   logic [baro_pkg::H_W-1:0] j_h;
   logic                n_sat;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_ST; s++) vld_ff[s] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int s = 1; s < NUM_ST; s++) vld_ff[s] <= vld_ff[s-1];
      end
   end

   always_comb begin
      itm_in[0].pos = (req_pressure_mb_q8 > 0);
      itm_in[0].sat = 1'b0;
      itm_in[0].p   = req_pressure_mb_q8[PP_W-1:0];
      itm_in[0].v   = req_variance_mb2_q16;
      itm_in[0].h   = '0;
      for (int s = 1; s < NUM_ST; s++) itm_in[s] = itm_ff[s-1];
      itm_in[ST_J].h   = j_h;
      itm_in[ST_N].sat = n_sat;
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_ST; s++) itm_ff[s] <= itm_in[s];
   end

   // ------------------------------------------------- log2(100 * p) stages
   baro_pkg::norm_type          b_n_ff;
   logic [baro_pkg::LOGV_W-1:0] c_t0_ff;
   logic [baro_pkg::LOGV_W-1:0] c_t1_ff;
   logic [LOG_SH-1:0]           c_fr_ff;
   logic [4:0]                  c_k_ff;
   logic [LV_W-1:0]             d_l1_ff;
   logic [LOG_TABLE_BITS-1:0]   b_idx;

   assign b_idx = b_n_ff.off[29:LOG_SH];

   always_ff @(posedge clock) begin
      b_n_ff  <= baro_pkg::normalize(30'(itm_ff[0].p) * 30'(baro_pkg::MILLIBAR_PA));
      c_t0_ff <= log_tab[TAB_IW'(b_idx)];
      c_t1_ff <= log_tab[TAB_IW'(b_idx) + TAB_IW'(1)];
      c_fr_ff <= b_n_ff.off[LOG_SH-1:0];
      c_k_ff  <= b_n_ff.k;
      d_l1_ff <= {c_k_ff, 24'b0} + LV_W'(log_interp(c_t0_ff, c_t1_ff, c_fr_ff));
   end

   // ------------------------------------- Y = (L1 - L2) * e, then 2^Y
   logic signed [29:0]          ys;
   logic signed [50:0]          yprod;
   logic signed [29:0]          e_y_ff;
   logic [LOG_TABLE_BITS-1:0]   f_idx;
   logic [baro_pkg::EXPV_W-1:0] f_t0_ff;
   logic [baro_pkg::EXPV_W-1:0] f_t1_ff;
   logic [EXP_SH-1:0]           f_fr_ff;
   logic signed [5:0]           f_n_ff;
   logic [baro_pkg::EXPV_W-1:0] g_mant_ff;
   logic signed [5:0]           g_n_ff;
   logic [63:0]                 rpow_full;
   logic [RP_W-1:0]             h_rpow_ff;

   assign ys    = $signed({1'b0, d_l1_ff}) - $signed({1'b0, l2_ff});
   assign yprod = 51'(ys) * 51'($signed({1'b0, ex_ff}));
   assign f_idx = e_y_ff[23:EXP_SH];

   always_comb begin
      if (g_n_ff >= 0) rpow_full = 64'(g_mant_ff) << g_n_ff[4:0];
      else             rpow_full = 64'(g_mant_ff) >> (6'(-g_n_ff));
   end

   always_ff @(posedge clock) begin
      e_y_ff    <= yprod[49:20];
      f_t0_ff   <= exp_tab[TAB_IW'(f_idx)];
      f_t1_ff   <= exp_tab[TAB_IW'(f_idx) + TAB_IW'(1)];
      f_fr_ff   <= e_y_ff[EXP_SH-1:0];
      f_n_ff    <= e_y_ff[29:24];
      g_mant_ff <= exp_interp(f_t0_ff, f_t1_ff, f_fr_ff);
      g_n_ff    <= f_n_ff;
      h_rpow_ff <= rpow_full[RP_W-1:0];
   end

   // ------------------------------------------ height and gain numerator
   localparam logic [RP_W-1:0] ONE_Q30 = RP_W'(1) << 30;

   logic            i_neg;
   logic [RP_W-1:0] i_mag;
   logic            i_neg_ff;
   logic [63:0]     i_mk_lo_ff;
   logic [63:0]     i_mk_hi_ff;
   logic [44:0]     i_erl_ff;
   logic [44:0]     i_erh_ff;
   logic [89:0]     j_prod;
   logic [60:0]     j_x;
   logic [60:0]     j_xr;
   logic [A_W-1:0]  j_a_ff;
   logic [62:0]     k_ak_lo_ff;
   logic [61:0]     k_ak_hi_ff;
   logic [87:0]     m_full;
   logic [85:0]     m_nq_raw;
   logic [63:0]     m_nq_ff;

   assign i_neg = h_rpow_ff > ONE_Q30;
   assign i_mag = i_neg ? h_rpow_ff - ONE_Q30 : ONE_Q30 - h_rpow_ff;

   assign j_prod = (90'(i_mk_hi_ff) << 25) + 90'(i_mk_lo_ff);
   assign j_x    = j_prod[89:29];
   assign j_xr   = (j_x + 61'd1) >> 1;

   always_comb begin
      if (i_neg_ff) begin
         j_h = (j_xr > (61'd1 << 26)) ? {1'b1, {(baro_pkg::H_W-1){1'b0}}}
                                      : baro_pkg::H_W'(-j_xr);
      end else begin
         j_h = (j_xr > ((61'd1 << 26) - 61'd1)) ? {1'b0, {(baro_pkg::H_W-1){1'b1}}}
                                                : baro_pkg::H_W'(j_xr);
      end
   end

   assign m_full   = (88'(k_ak_hi_ff) << 24) + 88'(k_ak_lo_ff);
   assign m_nq_raw = m_full[87:2];

   always_ff @(posedge clock) begin
      i_neg_ff   <= i_neg;
      i_mk_lo_ff <= 64'(i_mag[24:0]) * 64'(knum_ff);
      i_mk_hi_ff <= 64'(i_mag[RP_W-1:25]) * 64'(knum_ff);
      i_erl_ff   <= 45'(ex_ff) * 45'(h_rpow_ff[24:0]);
      i_erh_ff   <= 45'(ex_ff) * 45'(h_rpow_ff[RP_W-1:25]);
      j_a_ff     <= (A_W'(i_erh_ff) << 1) + A_W'(i_erl_ff[44:24]);
      k_ak_lo_ff <= 63'(j_a_ff[23:0]) * 63'(knum_ff);
      k_ak_hi_ff <= 62'(j_a_ff[A_W-1:24]) * 62'(knum_ff);
      // anything at or above 2^63 already puts the gain past 2^44
      m_nq_ff    <= (m_nq_raw >= (86'd1 << 63)) ? (64'd1 << 63) : m_nq_raw[63:0];
   end

   // -------------------------------------------- gain G = nq / p, bit a stage
   logic [PP_W-1:0] drem_ff [G_W+1];
   logic [G_W-1:0]  ddq_ff  [G_W+1];
   logic [PP_W-1:0] drem_in [G_W+1];
   logic [G_W-1:0]  ddq_in  [G_W+1];

   assign n_sat = m_nq_ff >= (64'(itm_ff[ST_N-1].p) << G_W);

   always_comb begin
      logic [PP_W:0] trial;
      logic [PP_W:0] dvs;
      logic          ge;
      drem_in[0] = m_nq_ff[62:G_W];
      ddq_in[0]  = m_nq_ff[G_W-1:0];
      for (int s = 0; s < G_W; s++) begin
         trial = {drem_ff[s], ddq_ff[s][G_W-1]};
         dvs   = {1'b0, itm_ff[ST_N+s].p};
         ge    = trial >= dvs;
         drem_in[s+1] = ge ? PP_W'(trial - dvs) : trial[PP_W-1:0];
         ddq_in[s+1]  = {ddq_ff[s][G_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= G_W; s++) begin
         drem_ff[s] <= drem_in[s];
         ddq_ff[s]  <= ddq_in[s];
      end
   end

   // ------------------------------------------- var = (G^2 >> 24) * v >> 24
   localparam int GH = G_W / 2;

   logic [G_W-1:0]  g_val;
   logic [43:0]     p_hh_ff;
   logic [43:0]     p_hl_ff;
   logic [43:0]     p_ll_ff;
   logic [87:0]     q_sq;
   logic [63:0]     q_q_ff;
   logic [63:0]     r_lo_ff;
   logic [63:0]     r_hi_ff;
   logic [95:0]     o_full;
   logic [71:0]     o_var;
   logic [baro_pkg::HV_W-1:0] o_var_sat;

   assign g_val = ddq_ff[G_W];
   assign q_sq  = (88'(p_hh_ff) << G_W) + (88'(p_hl_ff) << (GH + 1)) + 88'(p_ll_ff);

   always_ff @(posedge clock) begin
      p_hh_ff <= 44'(g_val[G_W-1:GH]) * 44'(g_val[G_W-1:GH]);
      p_hl_ff <= 44'(g_val[G_W-1:GH]) * 44'(g_val[GH-1:0]);
      p_ll_ff <= 44'(g_val[GH-1:0]) * 44'(g_val[GH-1:0]);
      q_q_ff  <= q_sq[87:24];
      r_lo_ff <= 64'(q_q_ff[31:0]) * 64'(itm_ff[NUM_ST-2].v);
      r_hi_ff <= 64'(q_q_ff[63:32]) * 64'(itm_ff[NUM_ST-2].v);
   end

   assign o_full = (96'(r_hi_ff) << 32) + 96'(r_lo_ff);
   assign o_var  = o_full[95:24];

   always_comb begin
      if (itm_ff[NUM_ST-1].sat && (itm_ff[NUM_ST-1].v != '0)) begin
         o_var_sat = '1;
      end else if (o_var > 72'({baro_pkg::HV_W{1'b1}})) begin
         o_var_sat = '1;
      end else begin
         o_var_sat = o_var[baro_pkg::HV_W-1:0];
      end
   end

   // ---------------------------------------------------------------- output
   logic                      rsp_strobe_ff;
   logic [baro_pkg::H_W-1:0]  rsp_h_ff;
   logic [baro_pkg::HV_W-1:0] rsp_var_ff;
   logic                      rsp_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= vld_ff[NUM_ST-1];
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff  <= itm_ff[NUM_ST-1].pos;
      rsp_h_ff   <= itm_ff[NUM_ST-1].pos ? itm_ff[NUM_ST-1].h : '0;
      rsp_var_ff <= itm_ff[NUM_ST-1].pos ? o_var_sat : '0;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_height_mm      = $signed(rsp_h_ff);
   assign rsp_height_var_mm2 = rsp_var_ff;
   assign rsp_valid_res      = rsp_ok_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("transaction produced no result at the expected cycle");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching transaction");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |-> (rsp_height_mm == 0 && rsp_height_var_mm2 == 0))
      else $error("invalid pressure gave a nonzero result");

   a_busy_div: assert property (@(posedge clock) disable iff (reset)
      (csr_we && !reset) |=> busy ##1 busy)
      else $error("config write did not hold off transactions");
`endif

endmodule

`default_nettype wire
